@@ rtl/swept_sphere_intersect_assert.svh @@
// Assertion macros for the swept sphere block.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef SWEPT_SPHERE_INTERSECT_ASSERT_SVH
`define SWEPT_SPHERE_INTERSECT_ASSERT_SVH
`ifndef SYNTHESIS
`define SSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSI_ASSERT_IMP(lbl, ante, cons, msg)
`define SSI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/ssi_pkg.sv @@
package ssi_pkg;

  // Port and field widths
  localparam int unsigned IN_TDATA_W  = 352;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned CRD_W       = 32;
  localparam int unsigned RAD_W       = 31;
  localparam int unsigned NRM_W       = 18;

  // Internal datapath widths, sized from the input ranges
  localparam int unsigned DIF_W  = 33;  // coordinate difference
  localparam int unsigned RS_W   = 32;  // radius sum
  localparam int unsigned SQ_W   = 66;  // squared length, dot product
  localparam int unsigned LEN_W  = 33;  // path length
  localparam int unsigned VMAG_W = 34;  // projection magnitude
  localparam int unsigned V2_W   = 68;
  localparam int unsigned DSC_W  = 70;  // discriminant, padded even
  localparam int unsigned DRT_W  = 35;  // discriminant root
  localparam int unsigned T_W    = 37;  // signed contact distance
  localparam int unsigned TMAG_W = 36;
  localparam int unsigned PRD_W  = 69;  // |D_i| * |t|
  localparam int unsigned PM_W   = 37;  // contact offset magnitude
  localparam int unsigned NV_W   = 38;  // signed normal vector component
  localparam int unsigned NVM_W  = 37;
  localparam int unsigned NN_W   = 74;  // squared normal length
  localparam int unsigned NL_W   = 37;

  // Magnitude of a signed coordinate difference
  function automatic logic [DIF_W-1:0] abs_dif(input logic [DIF_W-1:0] x);
    abs_dif = x[DIF_W-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

@@ rtl/ssi_sqrt.sv @@
// Pipelined integer square root, one root bit per register stage.
module ssi_sqrt #(
  parameter int unsigned IW  = 66,
  parameter int unsigned SBW = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [IW-1:0]  rad_i,
  input  logic [SBW-1:0] sb_i,
  output logic           vld_o,
  output logic [IW/2-1:0] root_o,
  output logic [SBW-1:0] sb_o
);
  localparam int unsigned RW = IW / 2;

  logic            vld_q  [RW];
  logic [IW-1:0]   x_q    [RW];
  logic [RW-1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SBW-1:0]  sb_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic            vin;
    logic [IW-1:0]   xin;
    logic [RW-1:0]   rin;
    logic [RW-1:0]   qin;
    logic [SBW-1:0]  sbin;
    logic [RW+1:0]   cand;
    logic [RW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign vin  = vld_i;
      assign xin  = rad_i;
      assign rin  = '0;
      assign qin  = '0;
      assign sbin = sb_i;
    end else begin : g_next
      assign vin  = vld_q[k-1];
      assign xin  = x_q[k-1];
      assign rin  = rem_q[k-1];
      assign qin  = root_q[k-1];
      assign sbin = sb_q[k-1];
    end

    // Try the next root bit against the remainder with two more radicand bits
    assign cand  = {rin, xin[IW-1 -: 2]};
    assign trial = {qin, 2'b01};
    assign ge    = (cand >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= {xin[IW-3:0], 2'b00};
        rem_q[k]  <= ge ? RW'(cand - trial) : cand[RW-1:0];
        root_q[k] <= {qin[RW-2:0], ge};
        sb_q[k]   <= sbin;
      end
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];
  assign sb_o   = sb_q[RW-1];

endmodule

@@ rtl/ssi_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Lanes share one divisor. The numerator must satisfy num < d << QW.
module ssi_div #(
  parameter int unsigned NW    = 66,
  parameter int unsigned DW    = 33,
  parameter int unsigned QW    = 34,
  parameter int unsigned LANES = 1,
  parameter int unsigned SBW   = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SBW-1:0]             sb_i,
  output logic                       vld_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SBW-1:0]             sb_o
);
  logic                       vld_q [QW];
  logic [LANES-1:0][DW-1:0]   rem_q [QW];
  logic [LANES-1:0][QW-1:0]   lo_q  [QW];
  logic [LANES-1:0][QW-1:0]   quo_q [QW];
  logic [DW-1:0]              den_q [QW];
  logic [SBW-1:0]             sb_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                       vin;
    logic [LANES-1:0][DW-1:0]   rin;
    logic [LANES-1:0][QW-1:0]   lin;
    logic [LANES-1:0][QW-1:0]   qin;
    logic [DW-1:0]              din;
    logic [SBW-1:0]             sbin;
    logic [LANES-1:0][DW:0]     cand;
    logic [LANES-1:0][DW-1:0]   rnx;
    logic [LANES-1:0][QW-1:0]   lnx;
    logic [LANES-1:0][QW-1:0]   qnx;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rin[l] = DW'(num_i[l] >> QW);
          lin[l] = num_i[l][QW-1:0];
        end
      end
      assign vin  = vld_i;
      assign qin  = '0;
      assign din  = den_i;
      assign sbin = sb_i;
    end else begin : g_next
      assign vin  = vld_q[k-1];
      assign rin  = rem_q[k-1];
      assign lin  = lo_q[k-1];
      assign qin  = quo_q[k-1];
      assign din  = den_q[k-1];
      assign sbin = sb_q[k-1];
    end

    // Shift in one numerator bit, subtract the divisor where it fits
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        cand[l] = {rin[l], lin[l][QW-1]};
        lnx[l]  = {lin[l][QW-2:0], 1'b0};
        if (cand[l] >= {1'b0, din}) begin
          rnx[l] = DW'(cand[l] - {1'b0, din});
          qnx[l] = {qin[l][QW-2:0], 1'b1};
        end else begin
          rnx[l] = cand[l][DW-1:0];
          qnx[l] = {qin[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rnx;
        lo_q[k]  <= lnx;
        quo_q[k] <= qnx;
        den_q[k] <= din;
        sb_q[k]  <= sbin;
      end
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = quo_q[QW-1];
  assign sb_o  = sb_q[QW-1];

endmodule

@@ rtl/swept_sphere_intersect.sv @@
// Channel  | Dir | Contents (tdata, lowest bit first)
// s_axis   | in  | start x/y/z, stop x/y/z, center x/y/z (32 each), target_radius,
//          |     | mover_radius (31 each), 2 zero pad bits
// m_axis   | out | hit, contact_distance (32), normal x/y/z (18 each), 1 zero pad bit
//
// One transaction per cycle sustained while the output is not stalled; the pipeline holds
// three bit-serial square roots and three shift-subtract dividers.
// Reset clears only the valid bits; payload registers are not reset.
// A stalled output holds the whole pipeline, s_axis_tready follows that enable.
module swept_sphere_intersect
  import ssi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // start xyz, stop xyz, center xyz, radii
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // hit, contact_distance, normal xyz
);

  localparam int unsigned NQ_W = FRAC_BITS + 2;
  localparam int unsigned NN_NUM_W = NVM_W + FRAC_BITS;
  localparam logic [NQ_W-1:0] ONE_Q = {2'b01, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic                       ddz;
    logic                       edneg;
    logic [SQ_W-1:0]            edmag;
    logic [SQ_W-1:0]            ee;
    logic [RS_W-1:0]            rsum;
    logic [2:0][DIF_W-1:0]      dv;
    logic [2:0][DIF_W-1:0]      ev;
  } len_sb_t;

  typedef struct packed {
    logic                       ddz;
    logic                       edneg;
    logic [SQ_W-1:0]            ee;
    logic [RS_W-1:0]            rsum;
    logic [LEN_W-1:0]           len;
    logic [2:0][DIF_W-1:0]      dv;
    logic [2:0][DIF_W-1:0]      ev;
  } proj_sb_t;

  typedef struct packed {
    logic                       ddz;
    logic                       nohit;
    logic                       edneg;
    logic [VMAG_W-1:0]          vmag;
    logic [LEN_W-1:0]           len;
    logic [2:0][DIF_W-1:0]      dv;
    logic [2:0][DIF_W-1:0]      ev;
  } disc_sb_t;

  typedef struct packed {
    logic                       ddz;
    logic                       nohit;
    logic [CRD_W-1:0]           contact;
  } res_t;

  typedef struct packed {
    res_t                       r;
    logic [2:0]                 pneg;
    logic [2:0][DIF_W-1:0]      ev;
  } off_sb_t;

  typedef struct packed {
    res_t                       r;
    logic [2:0]                 nvneg;
    logic [2:0][NVM_W-1:0]      nvmag;
  } nrm_sb_t;

  typedef struct packed {
    res_t                       r;
    logic [2:0]                 nvneg;
    logic                       nlz;
  } out_sb_t;

  logic adv;
  logic out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // Advance every stage unless a finished result is held
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------- Stage 1: differences ----------------
  logic [2:0][CRD_W-1:0] st_w, sp_w, ct_w;
  logic [RAD_W-1:0] tr_w, mr_w;
  assign st_w = s_axis_tdata[95:0];
  assign sp_w = s_axis_tdata[191:96];
  assign ct_w = s_axis_tdata[287:192];
  assign tr_w = s_axis_tdata[318:288];
  assign mr_w = s_axis_tdata[349:319];

  logic                  v1_q;
  logic [2:0][DIF_W-1:0] dv1_d, ev1_d, dv1_q, ev1_q;
  logic [RS_W-1:0]       rs1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv1_d[i] = {sp_w[i][CRD_W-1], sp_w[i]} - {st_w[i][CRD_W-1], st_w[i]};
      ev1_d[i] = {ct_w[i][CRD_W-1], ct_w[i]} - {st_w[i][CRD_W-1], st_w[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv1_q <= dv1_d;
      ev1_q <= ev1_d;
      rs1_q <= {1'b0, tr_w} + {1'b0, mr_w};
    end
  end

  // ---------------- Stage 2: squares and component products ----------------
  logic                  v2_q;
  logic [2:0][SQ_W-1:0]  dd2_d, ee2_d, de2_d, dd2_q, ee2_q, de2_q;
  logic [2:0]            dn2_q;
  logic [2:0][DIF_W-1:0] dv2_q, ev2_q;
  logic [RS_W-1:0]       rs2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd2_d[i] = SQ_W'(abs_dif(dv1_q[i])) * SQ_W'(abs_dif(dv1_q[i]));
      ee2_d[i] = SQ_W'(abs_dif(ev1_q[i])) * SQ_W'(abs_dif(ev1_q[i]));
      de2_d[i] = SQ_W'(abs_dif(dv1_q[i])) * SQ_W'(abs_dif(ev1_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd2_q <= dd2_d;
      ee2_q <= ee2_d;
      de2_q <= de2_d;
      for (int i = 0; i < 3; i++) begin
        dn2_q[i] <= dv1_q[i][DIF_W-1] ^ ev1_q[i][DIF_W-1];
      end
      dv2_q <= dv1_q;
      ev2_q <= ev1_q;
      rs2_q <= rs1_q;
    end
  end

  // ---------------- Stage 3: sums ----------------
  logic                  v3_q;
  logic [SQ_W-1:0]       dd3_q, ee3_q, pos3_q, neg3_q, pos3_d, neg3_d;
  logic [2:0][DIF_W-1:0] dv3_q, ev3_q;
  logic [RS_W-1:0]       rs3_q;

  // Split the dot product by sign so that both halves stay unsigned
  always_comb begin
    pos3_d = '0;
    neg3_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (dn2_q[i]) begin
        neg3_d = neg3_d + de2_q[i];
      end else begin
        pos3_d = pos3_d + de2_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd3_q  <= dd2_q[0] + dd2_q[1] + dd2_q[2];
      ee3_q  <= ee2_q[0] + ee2_q[1] + ee2_q[2];
      pos3_q <= pos3_d;
      neg3_q <= neg3_d;
      dv3_q  <= dv2_q;
      ev3_q  <= ev2_q;
      rs3_q  <= rs2_q;
    end
  end

  // ---------------- Stage 4: dot product sign and magnitude ----------------
  logic            v4_q;
  logic [SQ_W-1:0] dd4_q;
  len_sb_t         len_sb_d, len_sb_q;

  always_comb begin
    len_sb_d.ddz   = (dd3_q == '0);
    len_sb_d.edneg = (pos3_q < neg3_q);
    len_sb_d.edmag = len_sb_d.edneg ? (neg3_q - pos3_q) : (pos3_q - neg3_q);
    len_sb_d.ee    = ee3_q;
    len_sb_d.rsum  = rs3_q;
    len_sb_d.dv    = dv3_q;
    len_sb_d.ev    = ev3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd4_q    <= dd3_q;
      len_sb_q <= len_sb_d;
    end
  end

  // ---------------- Path length ----------------
  logic             len_vld;
  logic [LEN_W-1:0] len_w;
  len_sb_t          len_sb_o;
  proj_sb_t         proj_sb_d;

  ssi_sqrt #(.IW(SQ_W), .SBW($bits(len_sb_t))) u_len_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (v4_q),
    .rad_i  (dd4_q),
    .sb_i   (len_sb_q),
    .vld_o  (len_vld),
    .root_o (len_w),
    .sb_o   (len_sb_o)
  );

  assign proj_sb_d.ddz   = len_sb_o.ddz;
  assign proj_sb_d.edneg = len_sb_o.edneg;
  assign proj_sb_d.ee    = len_sb_o.ee;
  assign proj_sb_d.rsum  = len_sb_o.rsum;
  assign proj_sb_d.len   = len_w;
  assign proj_sb_d.dv    = len_sb_o.dv;
  assign proj_sb_d.ev    = len_sb_o.ev;

  // ---------------- Projection on the unit direction ----------------
  logic                         proj_vld;
  logic [0:0][VMAG_W-1:0]       vmag_w;
  proj_sb_t                     proj_sb_o;

  ssi_div #(
    .NW(SQ_W), .DW(LEN_W), .QW(VMAG_W), .LANES(1), .SBW($bits(proj_sb_t))
  ) u_proj_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (len_vld),
    .num_i  (len_sb_o.edmag),
    .den_i  (len_w),
    .sb_i   (proj_sb_d),
    .vld_o  (proj_vld),
    .quo_o  (vmag_w),
    .sb_o   (proj_sb_o)
  );

  // ---------------- Stage Q: squares of projection and radius sum ----------------
  logic            vq_q;
  logic [V2_W-1:0] v2q_q;
  logic [63:0]     r2q_q;
  logic [SQ_W-1:0] eeq_q;
  disc_sb_t        dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq_q <= 1'b0;
    end else if (adv) begin
      vq_q <= proj_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v2q_q       <= V2_W'(vmag_w[0]) * V2_W'(vmag_w[0]);
      r2q_q       <= 64'(proj_sb_o.rsum) * 64'(proj_sb_o.rsum);
      eeq_q       <= proj_sb_o.ee;
      dq_q.ddz    <= proj_sb_o.ddz;
      dq_q.nohit  <= 1'b0;
      dq_q.edneg  <= proj_sb_o.edneg;
      dq_q.vmag   <= vmag_w[0];
      dq_q.len    <= proj_sb_o.len;
      dq_q.dv     <= proj_sb_o.dv;
      dq_q.ev     <= proj_sb_o.ev;
    end
  end

  // ---------------- Stage R: discriminant ----------------
  logic             vr_q;
  logic [DSC_W-1:0] sum_r_w, dsc_r_q;
  disc_sb_t         dr_d, dr_q;

  assign sum_r_w = DSC_W'(v2q_q) + DSC_W'(r2q_q);

  // Flag a miss when the discriminant goes negative
  always_comb begin
    dr_d       = dq_q;
    dr_d.nohit = (sum_r_w < DSC_W'(eeq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (adv) begin
      vr_q <= vq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dsc_r_q <= sum_r_w - DSC_W'(eeq_q);
      dr_q    <= dr_d;
    end
  end

  // ---------------- Discriminant root ----------------
  logic             drt_vld;
  logic [DRT_W-1:0] drt_w;
  disc_sb_t         drt_sb_o;

  ssi_sqrt #(.IW(DSC_W), .SBW($bits(disc_sb_t))) u_disc_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vr_q),
    .rad_i  (dsc_r_q),
    .sb_i   (dr_q),
    .vld_o  (drt_vld),
    .root_o (drt_w),
    .sb_o   (drt_sb_o)
  );

  // ---------------- Stage T: contact distance ----------------
  logic                   vt_q;
  logic signed [T_W-1:0]  v_t_w, t_t_w;
  logic [CRD_W-1:0]       cont_t_w;
  logic [TMAG_W-1:0]      tmag_t_q;
  logic                   tneg_t_q;
  res_t                   rt_q;
  logic [LEN_W-1:0]       len_t_q;
  logic [2:0][DIF_W-1:0]  dv_t_q, ev_t_q;

  always_comb begin
    v_t_w = drt_sb_o.edneg ? -$signed({3'b000, drt_sb_o.vmag})
                           : $signed({3'b000, drt_sb_o.vmag});
    t_t_w = v_t_w - $signed({2'b00, drt_w});
    // Saturate to the 32 bit result range
    if (!t_t_w[T_W-1] && (t_t_w[T_W-2:CRD_W-1] != '0)) begin
      cont_t_w = {1'b0, {(CRD_W-1){1'b1}}};
    end else if (t_t_w[T_W-1] && (t_t_w[T_W-2:CRD_W-1] != '1)) begin
      cont_t_w = {1'b1, {(CRD_W-1){1'b0}}};
    end else begin
      cont_t_w = t_t_w[CRD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vt_q <= 1'b0;
    end else if (adv) begin
      vt_q <= drt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tmag_t_q   <= TMAG_W'(t_t_w[T_W-1] ? -t_t_w : t_t_w);
      tneg_t_q   <= t_t_w[T_W-1];
      rt_q.ddz   <= drt_sb_o.ddz;
      rt_q.nohit <= drt_sb_o.nohit;
      rt_q.contact <= cont_t_w;
      len_t_q    <= drt_sb_o.len;
      dv_t_q     <= drt_sb_o.dv;
      ev_t_q     <= drt_sb_o.ev;
    end
  end

  // ---------------- Stage M: direction times distance ----------------
  logic                   vm_q;
  logic [2:0][PRD_W-1:0]  prd_m_q;
  logic [LEN_W-1:0]       len_m_q;
  off_sb_t                om_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (adv) begin
      vm_q <= vt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prd_m_q[i] <= PRD_W'(abs_dif(dv_t_q[i])) * PRD_W'(tmag_t_q);
        om_q.pneg[i] <= dv_t_q[i][DIF_W-1] ^ tneg_t_q;
      end
      len_m_q <= len_t_q;
      om_q.r  <= rt_q;
      om_q.ev <= ev_t_q;
    end
  end

  // ---------------- Contact offset ----------------
  logic                 off_vld;
  logic [2:0][PM_W-1:0] pm_w;
  off_sb_t              off_sb_o;

  ssi_div #(
    .NW(PRD_W), .DW(LEN_W), .QW(PM_W), .LANES(3), .SBW($bits(off_sb_t))
  ) u_off_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vm_q),
    .num_i  (prd_m_q),
    .den_i  (len_m_q),
    .sb_i   (om_q),
    .vld_o  (off_vld),
    .quo_o  (pm_w),
    .sb_o   (off_sb_o)
  );

  // ---------------- Stage N: contact to center vector ----------------
  logic                  vn_q;
  logic [2:0][NV_W-1:0]  nv_n_d, nv_n_q;
  res_t                  rn_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv_n_d[i] = {{(NV_W-DIF_W){off_sb_o.ev[i][DIF_W-1]}}, off_sb_o.ev[i]}
                - (off_sb_o.pneg[i] ? -{1'b0, pm_w[i]} : {1'b0, pm_w[i]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (adv) begin
      vn_q <= off_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nv_n_q <= nv_n_d;
      rn_q   <= off_sb_o.r;
    end
  end

  // ---------------- Stage S: component squares ----------------
  logic                  vs_q;
  logic [2:0][NN_W-1:0]  sq_s_q;
  nrm_sb_t               ns_d, ns_q;

  always_comb begin
    ns_d.r = rn_q;
    for (int i = 0; i < 3; i++) begin
      ns_d.nvneg[i] = nv_n_q[i][NV_W-1];
      ns_d.nvmag[i] = NVM_W'(nv_n_q[i][NV_W-1] ? -nv_n_q[i] : nv_n_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (adv) begin
      vs_q <= vn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_s_q[i] <= NN_W'(ns_d.nvmag[i]) * NN_W'(ns_d.nvmag[i]);
      end
      ns_q <= ns_d;
    end
  end

  // ---------------- Stage A: squared normal length ----------------
  logic            va_q;
  logic [NN_W-1:0] nn_a_q;
  nrm_sb_t         na_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nn_a_q <= sq_s_q[0] + sq_s_q[1] + sq_s_q[2];
      na_q   <= ns_q;
    end
  end

  // ---------------- Normal length ----------------
  logic                     nl_vld;
  logic [NL_W-1:0]          nl_w;
  nrm_sb_t                  nl_sb_o;
  out_sb_t                  ob_d;
  logic [2:0][NN_NUM_W-1:0] nnum_w;

  ssi_sqrt #(.IW(NN_W), .SBW($bits(nrm_sb_t))) u_nrm_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (va_q),
    .rad_i  (nn_a_q),
    .sb_i   (na_q),
    .vld_o  (nl_vld),
    .root_o (nl_w),
    .sb_o   (nl_sb_o)
  );

  always_comb begin
    ob_d.r     = nl_sb_o.r;
    ob_d.nvneg = nl_sb_o.nvneg;
    ob_d.nlz   = (nl_w == '0);
    for (int i = 0; i < 3; i++) begin
      nnum_w[i] = {nl_sb_o.nvmag[i], {FRAC_BITS{1'b0}}};
    end
  end

  // ---------------- Normal division ----------------
  logic                 nq_vld;
  logic [2:0][NQ_W-1:0] nq_w;
  out_sb_t              ob_o;

  ssi_div #(
    .NW(NN_NUM_W), .DW(NL_W), .QW(NQ_W), .LANES(3), .SBW($bits(out_sb_t))
  ) u_nrm_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (nl_vld),
    .num_i  (nnum_w),
    .den_i  (nl_w),
    .sb_i   (ob_d),
    .vld_o  (nq_vld),
    .quo_o  (nq_w),
    .sb_o   (ob_o)
  );

  // ---------------- Output register ----------------
  logic                          hit_w;
  logic [2:0][NRM_W-1:0]         nrm_w;
  logic [NQ_W-1:0]               mlim_w [3];
  logic signed [NQ_W:0]          msgn_w [3];
  logic signed [31:0]            mext_w [3];

  assign hit_w = !ob_o.r.ddz && !ob_o.r.nohit;

  // Limit each component to one, restore sign, drop to the port width
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mlim_w[i] = (nq_w[i] > ONE_Q) ? ONE_Q : nq_w[i];
      msgn_w[i] = ob_o.nvneg[i] ? -$signed({1'b0, mlim_w[i]}) : $signed({1'b0, mlim_w[i]});
      mext_w[i] = 32'(msgn_w[i]);
      nrm_w[i]  = (hit_w && !ob_o.nlz) ? mext_w[i][NRM_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= nq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {1'b0, nrm_w[2], nrm_w[1], nrm_w[0],
                     (hit_w ? ob_o.r.contact : {CRD_W{1'b0}}), hit_w};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------- Assertions ----------------
`include "swept_sphere_intersect_assert.svh"

  `SSI_ASSERT_IMP(a_miss_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[86:1] == '0, "miss result carries nonzero fields")
  `SSI_ASSERT_IMP(a_stall_blocks, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
  `SSI_ASSERT_NXT(a_stall_freeze, !s_axis_tready, $stable(vq_q) && $stable(v2q_q), "pipeline moved during stall")

endmodule

@@ verif/swept_sphere_intersect_test.sv @@
module swept_sphere_intersect_test;
  import ssi_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = FRAC + 190;
  localparam int unsigned N_RANDOM = 1430;

  typedef struct {
    logic signed [CRD_W-1:0] crd [9];  // start xyz, stop xyz, center xyz
    logic [RAD_W-1:0]        tgt_rad;
    logic [RAD_W-1:0]        mov_rad;
  } query_t;

  typedef struct packed {
    logic                    hit;
    logic [CRD_W-1:0]        cdist;
    logic [NRM_W-1:0]        nx;
    logic [NRM_W-1:0]        ny;
    logic [NRM_W-1:0]        nz;
  } contact_t;

  typedef struct {
    query_t   q;
    logic     typed;
    contact_t res;
  } row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  contact_t contact_q [$];
  row_t     sweep_rows [$];
  int       n_sent, n_seen, n_hits, n_errors;
  bit       calm;

  swept_sphere_intersect #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("timeout: %0d sent, %0d received", n_sent, n_seen);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [63:0] mag(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0]  root;
    logic [63:0]  c;
    logic [127:0] c2;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = root | (64'd1 << b);
      c2 = 128'(c) * 128'(c);
      if (c2 <= x) root = c;
    end
    return root;
  endfunction

  // Truncating divide, quotient saturated to 64 bits, zero divisor gives zero
  function automatic logic [63:0] div_sat(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    if (d == 0) return '0;
    q = n / 128'(d);
    return (q[127:64] != 0) ? '1 : q[63:0];
  endfunction

  // Swept sphere against target sphere: hit, distance to contact, contact normal
  function automatic contact_t sweep_contact(query_t q);
    contact_t     r;
    longint       dv [3];
    longint       ev [3];
    longint       nv [3];
    logic [127:0] dd, ee, pos, neg, nn, edm, sum;
    logic [63:0]  len, vmag, rsum, droot, tmag, nl, pm, m;
    longint       v, t, p;
    logic         edneg;
    r = '0;
    dd = '0; ee = '0; pos = '0; neg = '0; nn = '0;
    for (int i = 0; i < 3; i++) begin
      dv[i] = longint'(q.crd[3+i]) - longint'(q.crd[i]);
      ev[i] = longint'(q.crd[6+i]) - longint'(q.crd[i]);
      dd += 128'(mag(dv[i])) * 128'(mag(dv[i]));
      ee += 128'(mag(ev[i])) * 128'(mag(ev[i]));
      if ((dv[i] < 0) != (ev[i] < 0)) neg += 128'(mag(dv[i])) * 128'(mag(ev[i]));
      else pos += 128'(mag(dv[i])) * 128'(mag(ev[i]));
    end
    if (dd == 0) return r;
    len   = isqrt(dd);
    edneg = pos < neg;
    edm   = edneg ? neg - pos : pos - neg;
    vmag  = div_sat(edm, len);
    v     = edneg ? -longint'(vmag) : longint'(vmag);
    rsum  = 64'(q.tgt_rad) + 64'(q.mov_rad);
    sum   = 128'(rsum) * 128'(rsum) + 128'(vmag) * 128'(vmag);
    if (sum < ee) return r;
    droot = isqrt(sum - ee);
    t     = v - longint'(droot);
    r.hit = 1'b1;
    if (t > 64'sd2147483647) r.cdist = 32'h7fffffff;
    else if (t < -64'sd2147483648) r.cdist = 32'h80000000;
    else r.cdist = t[31:0];
    tmag = mag(t);
    for (int i = 0; i < 3; i++) begin
      pm    = div_sat(128'(mag(dv[i])) * 128'(tmag), len);
      p     = ((dv[i] < 0) != (t < 0)) ? -longint'(pm) : longint'(pm);
      nv[i] = ev[i] - p;
      nn   += 128'(mag(nv[i])) * 128'(mag(nv[i]));
    end
    nl = isqrt(nn);
    if (nl != 0) begin
      for (int i = 0; i < 3; i++) begin
        m = div_sat(128'(mag(nv[i])) << FRAC, nl);
        if (m > (64'd1 << FRAC)) m = 64'd1 << FRAC;
        m = nv[i] < 0 ? -m : m;
        case (i)
          0: r.nx = m[NRM_W-1:0];
          1: r.ny = m[NRM_W-1:0];
          default: r.nz = m[NRM_W-1:0];
        endcase
      end
    end
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_query(query_t q);
    return {2'b00, q.mov_rad, q.tgt_rad, q.crd[8], q.crd[7], q.crd[6], q.crd[5],
            q.crd[4], q.crd[3], q.crd[2], q.crd[1], q.crd[0]};
  endfunction

  function automatic query_t make_query(longint s0, longint s1, longint s2,
                                        longint e0, longint e1, longint e2,
                                        longint c0, longint c1, longint c2,
                                        longint tr, longint mr);
    query_t q;
    q.crd[0] = s0[31:0]; q.crd[1] = s1[31:0]; q.crd[2] = s2[31:0];
    q.crd[3] = e0[31:0]; q.crd[4] = e1[31:0]; q.crd[5] = e2[31:0];
    q.crd[6] = c0[31:0]; q.crd[7] = c1[31:0]; q.crd[8] = c2[31:0];
    q.tgt_rad = tr[30:0];
    q.mov_rad = mr[30:0];
    return q;
  endfunction

  function automatic void add_row(query_t q, logic typed, contact_t res);
    row_t row;
    row.q = q; row.typed = typed; row.res = res;
    sweep_rows.push_back(row);
  endfunction

  // Mostly small scenes around the origin, sometimes full-range coordinates
  function automatic query_t random_query();
    query_t      q;
    int unsigned span;
    bit          wild;
    wild = ($urandom_range(0, 9) == 0);
    span = $urandom_range(0, 3) == 0 ? 32'h0040_0000 : 32'h0014_0000;
    for (int i = 0; i < 9; i++)
      q.crd[i] = wild ? $urandom : int'($urandom_range(0, 2 * span)) - int'(span);
    if ($urandom_range(0, 15) == 0) q.crd[3 + $urandom_range(0, 2)] = q.crd[0];
    q.tgt_rad = wild ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 32'h0008_0000));
    q.mov_rad = wild ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 32'h0004_0000));
    return q;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one transaction and record its expected contact on acceptance
  task automatic send_query(query_t q, logic typed, contact_t res);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = IN_TDATA_W'({$urandom, $urandom});
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = pack_query(q);
    do @(posedge clk_i); while (!s_axis_tready);
    contact_q.push_back(typed ? res : sweep_contact(q));
    n_sent++;
  endtask

  // Random backpressure on the result side
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (calm || $urandom_range(0, 99) < 70) m_axis_tready = 1'b1;
      else begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 99) < 90 ? $urandom_range(0, 3) : $urandom_range(10, 40))
          @(negedge clk_i);
      end
    end
  end

  // Compare each result transaction with the oldest expected contact
  always @(posedge clk_i) begin
    contact_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[50:33],
             m_axis_tdata[68:51], m_axis_tdata[86:69]};
      n_seen++;
      if (contact_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result transaction %h", got);
      end else begin
        want = contact_q.pop_front();
        if (want.hit) n_hits++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("result %0d: hit %b/%b dist %h/%h n %h %h %h / %h %h %h (exp/act)",
                     n_seen, want.hit, got.hit, want.cdist, got.cdist,
                     want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
        end
      end
    end
  end

  initial begin
    contact_t zero, one_hit, ctr_hit;
    int       waited;
    longint   u;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    n_sent = 0; n_seen = 0; n_hits = 0; n_errors = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    u = 64'sd65536;
    zero = '0;
    one_hit = '0;
    one_hit.hit = 1'b1; one_hit.cdist = 32'd196608; one_hit.nx = 18'd65536;
    ctr_hit = '0;
    ctr_hit.hit = 1'b1; ctr_hit.cdist = 32'd131072;

    // zero-length paths, including the coordinate extremes
    add_row(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff), 1, zero);
    add_row(make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 0, 0, 0, 5, 5), 1, zero);
    add_row(make_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0), 1, zero);
    // clean miss and clean head-on hit
    add_row(make_query(0, 0, 0, u, 0, 0, 0, 100 * u, 0, u, u), 1, zero);
    add_row(make_query(0, 0, 0, 10 * u, 0, 0, 5 * u, 0, 0, u, u), 1, one_hit);
    // zero radii with the center on the path: contact lands at the center
    add_row(make_query(0, 0, 0, 4 * u, 0, 0, 2 * u, 0, 0, 0, 0), 1, ctr_hit);
    // contact behind the start
    add_row(make_query(0, 0, 0, 0, 3 * u, 0, 0, -2 * u, 0, 4 * u, u), 0, zero);
    add_row(make_query(0, 0, 0, -u, -u, -u, 5 * u, 5 * u, 5 * u, 20 * u, 0), 0, zero);
    // saturating distances, full-range coordinates
    add_row(make_query(32'h80000000, 0, 0, 32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0, 0, 0),
            0, zero);
    add_row(make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       0, 0), 0, zero);
    add_row(make_query(32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 32'h80000000, 0, 0,
                       32'h7fffffff, 32'h7fffffff), 0, zero);
    add_row(make_query(0, 0, 0, u, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff), 0, zero);
    add_row(make_query(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000001, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 0), 0, zero);
    // grazing contact and oblique hits
    add_row(make_query(0, 0, 0, 10 * u, 0, 0, 5 * u, 2 * u, 0, u, u), 0, zero);
    add_row(make_query(0, 0, 0, 10 * u, 0, 0, 5 * u, 2 * u, 0, u, u - 1), 0, zero);
    add_row(make_query(u, -2 * u, 3 * u, -7 * u, 6 * u, 2 * u, 0, 0, 0, 3 * u, 2 * u), 0, zero);
    add_row(make_query(1, 1, 1, 2, 2, 2, 3, 3, 3, 1, 1), 0, zero);
    add_row(make_query(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 0, zero);

    foreach (sweep_rows[i]) send_query(sweep_rows[i].q, sweep_rows[i].typed, sweep_rows[i].res);

    // random scenes, with an idle-free stretch now and then
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 0) calm = ($urandom_range(0, 2) == 0);
      send_query(random_query(), 1'b0, zero);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    calm = 1'b0;

    waited = 0;
    while (contact_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY + 50) @(posedge clk_i);
    if (contact_q.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived", contact_q.size());
    end

    $display("%0d queries checked (%0d directed), %0d hits, %0d mismatches",
             n_seen, sweep_rows.size(), n_hits, n_errors);
    if (n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ swept_sphere_intersect.f @@
+incdir+rtl
rtl/ssi_pkg.sv
rtl/ssi_sqrt.sv
rtl/ssi_div.sv
rtl/swept_sphere_intersect.sv
verif/swept_sphere_intersect_test.sv
